// ===== rtl/core/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types, codes and the CRC-32 byte update for the message set deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Last header-counter value of the offset field and of a 4-byte word
  localparam logic [2:0] HDR_LAST_OFFSET = 3'd7;
  localparam logic [2:0] HDR_LAST_WORD   = 3'd3;

  // Smallest legal size field (covers the CRC word)
  localparam logic [31:0] SIZE_MIN = 32'd4;

  // Result queue depth
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_OFFSET,
    PH_SIZE,
    PH_CRC,
    PH_MAGIC,
    PH_ATTR,
    PH_KEYLEN,
    PH_KEY,
    PH_VALLEN,
    PH_VALUE,
    PH_DONE,
    PH_TRAIL
  } phase_e;

  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_VALUE,
    KIND_STATUS
  } kind_e;

  typedef enum logic [2:0] {
    ST_GOOD,
    ST_CRC,
    ST_COMPRESSED,
    ST_TRUNCATED,
    ST_LENGTH
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       set_end;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         payload_byte;
    logic signed [63:0] message_offset;
    logic [2:0]         status;
    logic               key_null;
    logic               value_null;
    logic               last_of_run;
  } out_beat_t;

  // Up to two results from one byte: a key/value byte, then a status
  typedef struct packed {
    logic      has_data;
    logic      has_status;
    out_beat_t data_beat;
    out_beat_t status_beat;
  } res_pair_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msd_parser.sv =====
// ----------------------------------------------------------------------------
// msd_parser
// Message state, field capture, CRC and status for one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_parser import msd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_beat_t  beat_i,
  output res_pair_t      res_o
);

  localparam int unsigned CntW = LENGTH_BITS - 1;

  phase_e            phase_q, phase_d;
  logic [2:0]        hdr_cnt_q, hdr_cnt_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   size_q, size_d;
  logic [63:0]       shift_q, shift_d;
  logic [63:0]       offset_q, offset_d;
  logic [31:0]       exp_crc_q, exp_crc_d;
  logic [31:0]       crc_q, crc_d;
  logic [2:0]        attr_q, attr_d;
  logic [31:0]       key_len_q, key_len_d;
  logic [31:0]       val_len_q, val_len_d;
  logic              discard_q, discard_d;
  logic              key_null_q, key_null_d;
  logic              val_null_q, val_null_d;

  always_comb begin
    logic [7:0]  b;
    logic        set_end;
    logic        is_body;
    logic        fin;
    logic        ended;
    logic        do_start;
    logic        do_reset;
    logic [31:0] word;
    logic [31:0] cnt_next;
    status_e     st;
    kind_e       dkind;

    b        = beat_i.data_byte;
    set_end  = beat_i.set_end;
    is_body  = !(phase_q == PH_OFFSET || phase_q == PH_SIZE || phase_q == PH_CRC);
    fin      = 1'b0;
    ended    = 1'b0;
    do_start = 1'b0;
    do_reset = 1'b0;
    st       = ST_GOOD;
    dkind    = KIND_KEY;
    // shift only on a real step, a held byte must not be taken twice
    shift_d  = step_i ? {shift_q[55:0], b} : shift_q;
    word     = shift_d[31:0];
    cnt_next = 32'(cnt_q) + 32'd1;

    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    cnt_d      = cnt_q;
    size_d     = size_q;
    offset_d   = offset_q;
    exp_crc_d  = exp_crc_q;
    crc_d      = crc_q;
    attr_d     = attr_q;
    key_len_d  = key_len_q;
    val_len_d  = val_len_q;
    discard_d  = discard_q;
    key_null_d = key_null_q;
    val_null_d = val_null_q;
    res_o      = '0;

    if (step_i && discard_q) begin
      do_reset = set_end;
    end else if (step_i) begin
      if (is_body) begin
        crc_d  = crc32_byte(crc_q, b);
        size_d = size_q - CntW'(1);
      end
      unique case (phase_q)
        PH_OFFSET: begin
          if (hdr_cnt_q == HDR_LAST_OFFSET) begin
            offset_d  = shift_d;
            hdr_cnt_d = '0;
            phase_d   = PH_SIZE;
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        PH_SIZE: begin
          if (hdr_cnt_q == HDR_LAST_WORD) begin
            hdr_cnt_d = '0;
            if (word < SIZE_MIN || (word >> CntW) != 32'd0) begin
              res_o.has_status = 1'b1;
              st               = ST_LENGTH;
              discard_d        = 1'b1;
              ended            = 1'b1;
            end else begin
              size_d  = CntW'(word - SIZE_MIN);
              phase_d = PH_CRC;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        PH_CRC: begin
          if (hdr_cnt_q == HDR_LAST_WORD) begin
            hdr_cnt_d = '0;
            exp_crc_d = word;
            phase_d   = PH_MAGIC;
            fin       = (size_q == '0);
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        PH_MAGIC: phase_d = PH_ATTR;
        PH_ATTR: begin
          attr_d  = b[2:0];
          phase_d = PH_KEYLEN;
        end
        PH_KEYLEN: begin
          if (hdr_cnt_q == HDR_LAST_WORD) begin
            hdr_cnt_d = '0;
            cnt_d     = '0;
            key_len_d = word;
            if (word[31]) begin
              key_null_d = 1'b1;
              phase_d    = PH_VALLEN;
            end else begin
              phase_d = (word == 32'd0) ? PH_VALLEN : PH_KEY;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        PH_KEY: begin
          res_o.has_data = 1'b1;
          dkind          = KIND_KEY;
          if (cnt_next >= key_len_q) begin
            cnt_d   = '0;
            phase_d = PH_VALLEN;
          end else begin
            cnt_d = CntW'(cnt_next);
          end
        end
        PH_VALLEN: begin
          if (hdr_cnt_q == HDR_LAST_WORD) begin
            hdr_cnt_d = '0;
            cnt_d     = '0;
            val_len_d = word;
            if (word[31]) begin
              val_null_d = 1'b1;
              phase_d    = PH_DONE;
            end else begin
              phase_d = (word == 32'd0) ? PH_DONE : PH_VALUE;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        PH_VALUE: begin
          res_o.has_data = 1'b1;
          dkind          = KIND_VALUE;
          if (cnt_next >= val_len_q) begin
            cnt_d   = '0;
            phase_d = PH_DONE;
          end else begin
            cnt_d = CntW'(cnt_next);
          end
        end
        PH_DONE, PH_TRAIL: phase_d = PH_TRAIL;
        default: phase_d = PH_TRAIL;
      endcase

      if (is_body && size_d == '0) begin
        fin = 1'b1;
      end

      // end of message: CRC first, then compression, then framing
      if (fin) begin
        res_o.has_status = 1'b1;
        ended            = 1'b1;
        if ((crc_d ^ CRC_INIT) != exp_crc_d) begin
          st        = ST_CRC;
          discard_d = 1'b1;
        end else if (attr_d != 3'd0) begin
          st = ST_COMPRESSED;
        end else if (phase_d != PH_DONE) begin
          st = ST_LENGTH;
        end else begin
          st = ST_GOOD;
        end
      end

      if (set_end) begin
        if (!ended) begin
          res_o.has_status = 1'b1;
          st               = ST_TRUNCATED;
        end
        do_reset = 1'b1;
      end else begin
        do_start = ended;
      end
    end

    res_o.data_beat.kind           = dkind;
    res_o.data_beat.payload_byte   = b;
    res_o.data_beat.message_offset = offset_d;
    res_o.data_beat.status         = ST_GOOD;
    res_o.data_beat.key_null       = key_null_d;
    res_o.data_beat.value_null     = val_null_d;
    res_o.data_beat.last_of_run    = !res_o.has_status;

    res_o.status_beat.kind           = KIND_STATUS;
    res_o.status_beat.payload_byte   = 8'd0;
    res_o.status_beat.message_offset = offset_d;
    res_o.status_beat.status         = st;
    res_o.status_beat.key_null       = key_null_d;
    res_o.status_beat.value_null     = val_null_d;
    res_o.status_beat.last_of_run    = 1'b1;

    if (do_start || do_reset) begin
      phase_d    = PH_OFFSET;
      hdr_cnt_d  = '0;
      cnt_d      = '0;
      offset_d   = '0;
      crc_d      = CRC_INIT;
      attr_d     = '0;
      key_null_d = 1'b0;
      val_null_d = 1'b0;
    end
    if (do_reset) begin
      discard_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_OFFSET;
      hdr_cnt_q  <= '0;
      cnt_q      <= '0;
      offset_q   <= '0;
      crc_q      <= CRC_INIT;
      attr_q     <= '0;
      discard_q  <= 1'b0;
      key_null_q <= 1'b0;
      val_null_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      cnt_q      <= cnt_d;
      offset_q   <= offset_d;
      crc_q      <= crc_d;
      attr_q     <= attr_d;
      discard_q  <= discard_d;
      key_null_q <= key_null_d;
      val_null_q <= val_null_d;
    end
  end

  // field capture, no reset needed
  always_ff @(posedge clk_i) begin
    shift_q   <= shift_d;
    size_q    <= size_d;
    exp_crc_q <= exp_crc_d;
    key_len_q <= key_len_d;
    val_len_q <= val_len_d;
  end

  a_discard_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && discard_q |-> !res_o.has_data && !res_o.has_status)
    else $error("result while discarding");

  a_data_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.has_data |-> (phase_q == PH_KEY || phase_q == PH_VALUE))
    else $error("data beat outside key or value");

endmodule

`default_nettype wire

// ===== rtl/core/msd_res_fifo.sv =====
// ----------------------------------------------------------------------------
// msd_res_fifo
// Small result queue: takes one or two beats per cycle, gives one per cycle when popped.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_res_fifo import msd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire res_pair_t push_i,
  input  wire logic      pop_i,
  output logic           room_o,
  output logic           out_valid_o,
  output out_beat_t      out_beat_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  out_beat_t           mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     n_push;
  out_beat_t           first;
  logic                pop;

  assign n_push      = CntW'(push_i.has_data) + CntW'(push_i.has_status);
  assign first       = push_i.has_data ? push_i.data_beat : push_i.status_beat;
  assign out_valid_o = (count_q != '0);
  assign out_beat_o  = mem_q[rd_q];
  assign pop         = pop_i && out_valid_o;
  // two free places, judged on registered fill only
  assign room_o      = (count_q <= CntW'(FIFO_DEPTH - 2));

  assign wr_d    = wr_q + PtrW'(n_push);
  assign rd_d    = rd_q + PtrW'(pop);
  assign count_d = count_q + n_push - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != '0) begin
      mem_q[wr_q] <= first;
    end
    if (push_i.has_data && push_i.has_status) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.status_beat;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_push != '0 |-> count_q <= CntW'(FIFO_DEPTH - 2) || n_push == CntW'(1) &&
      count_q <= CntW'(FIFO_DEPTH - 1))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/log_message_set_deframer.sv =====
// ----------------------------------------------------------------------------
// log_message_set_deframer
// Streaming message set parser with CRC-32 check and per-message status.
// ----------------------------------------------------------------------------
// Takes a message set one byte per beat (set_end on the last byte) and
// sends out key bytes, value bytes and one status beat per message.
// Sustained rate is one input byte per cycle. A byte that gives two
// results (the last key or value byte together with the message status,
// or a byte followed by a truncation status) occupies the output for two
// beats; a four-entry result queue absorbs this, and the input stalls only
// when fewer than two queue places are free. A result passes through
// the input register, then the parser and the queue write, before it is
// on the output; a byte held back by a stall waits in the input register.
// After a CRC mismatch or an unframeable size the rest of the set is
// dropped silently up to set_end.
// ----------------------------------------------------------------------------
`default_nettype none

module log_message_set_deframer import msd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  // byte input
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_beat_i,
  // result output
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_beat_o
);

  logic      in_valid_q, in_valid_d;
  in_beat_t  in_q;
  logic      room;
  logic      step;
  logic      in_take;
  res_pair_t res;

  // held byte moves on when the queue has room for two results
  assign step       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_beat_i;
    end
  end

  msd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (in_q),
    .res_o  (res)
  );

  msd_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .pop_i       (!out_stall_i),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

  // a stall is only ever raised with a byte held
  a_stall_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with nothing held");

endmodule

`default_nettype wire

// ===== verif/msd_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msd_tb_pkg
// Byte-level prediction and result scoreboard for the message set deframer.
// ----------------------------------------------------------------------------
package msd_tb_pkg;
  import msd_pkg::*;

  // Width of the size field that the block treats as framable
  localparam int unsigned LEN_BITS = 32;
  localparam logic [31:0] SIZE_MAX = (32'd1 << (LEN_BITS - 1)) - 32'd1;

  // Bit-serial reflected CRC-32 update
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  class deframe_scoreboard;
    // parser state
    phase_e      phase;
    logic [31:0] byte_cnt;
    logic [63:0] shifter;
    logic [63:0] offset;
    logic [31:0] body_left;
    logic [31:0] crc_want;
    logic [31:0] crc_run;
    logic [7:0]  attr;
    logic [31:0] key_len;
    logic [31:0] val_len;
    logic        dropping;
    logic [1:0]  nulls;

    out_beat_t   fresh[$];
    out_beat_t   awaited[$];

    int unsigned errors;
    int unsigned live_bytes;
    int unsigned beats_checked;
    int unsigned status_seen[5];

    function new();
      errors        = 0;
      live_bytes    = 0;
      beats_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      power_up();
    endfunction

    function void clear_message();
      phase     = PH_OFFSET;
      byte_cnt  = '0;
      shifter   = '0;
      offset    = '0;
      body_left = '0;
      crc_want  = '0;
      crc_run   = CRC_INIT;
      attr      = '0;
      key_len   = '0;
      val_len   = '0;
      nulls     = '0;
    endfunction

    function void power_up();
      clear_message();
      dropping = 1'b0;
    endfunction

    function void emit(kind_e k, logic [7:0] p, status_e s);
      out_beat_t r;
      r.kind           = k;
      r.payload_byte   = p;
      r.message_offset = offset;
      r.status         = s;
      r.key_null       = nulls[0];
      r.value_null     = nulls[1];
      r.last_of_run    = 1'b0;
      fresh = {fresh, r};
    endfunction

    function bit take_field(logic [7:0] b, int unsigned n);
      shifter  = {shifter[55:0], b};
      byte_cnt = byte_cnt + 1;
      return byte_cnt >= n;
    endfunction

    function void next_field();
      shifter  = '0;
      byte_cnt = '0;
    endfunction

    // End of body: CRC first, then compression, then length fit
    function void close_message();
      status_e s;
      if (~crc_run != crc_want) begin
        s        = ST_CRC;
        dropping = 1'b1;
      end else if (attr[2:0] != 3'd0) begin
        s = ST_COMPRESSED;
      end else if (phase != PH_DONE) begin
        s = ST_LENGTH;
      end else begin
        s = ST_GOOD;
      end
      emit(KIND_STATUS, 8'h00, s);
    endfunction

    // Works out the result beats one accepted input byte causes
    function void parse_byte(in_beat_t beat);
      logic [7:0]  b;
      logic [31:0] v;
      bit          ended;
      b     = beat.data_byte;
      ended = 1'b0;
      fresh.delete();
      if (dropping) begin
        if (beat.set_end) power_up();
        return;
      end
      live_bytes++;
      case (phase)
        PH_OFFSET: begin
          if (take_field(b, 8)) begin
            offset = shifter;
            next_field();
            phase = PH_SIZE;
          end
        end
        PH_SIZE: begin
          if (take_field(b, 4)) begin
            v = shifter[31:0];
            next_field();
            if (v < SIZE_MIN || v > SIZE_MAX) begin
              emit(KIND_STATUS, 8'h00, ST_LENGTH);
              dropping = 1'b1;
              ended    = 1'b1;
            end else begin
              body_left = v - SIZE_MIN;
              phase     = PH_CRC;
            end
          end
        end
        PH_CRC: begin
          if (take_field(b, 4)) begin
            crc_want = shifter[31:0];
            next_field();
            phase = PH_MAGIC;
            if (body_left == 0) begin
              close_message();
              ended = 1'b1;
            end
          end
        end
        default: begin
          crc_run   = crc_step(crc_run, b);
          body_left = body_left - 1;
          case (phase)
            PH_MAGIC: phase = PH_ATTR;
            PH_ATTR: begin
              attr  = b;
              phase = PH_KEYLEN;
            end
            PH_KEYLEN: begin
              if (take_field(b, 4)) begin
                key_len = shifter[31:0];
                next_field();
                if (key_len[31]) begin
                  nulls[0] = 1'b1;
                  phase    = PH_VALLEN;
                end else begin
                  phase = (key_len == 0) ? PH_VALLEN : PH_KEY;
                end
              end
            end
            PH_KEY: begin
              emit(KIND_KEY, b, ST_GOOD);
              byte_cnt = byte_cnt + 1;
              if (byte_cnt >= key_len) begin
                byte_cnt = '0;
                phase    = PH_VALLEN;
              end
            end
            PH_VALLEN: begin
              if (take_field(b, 4)) begin
                val_len = shifter[31:0];
                next_field();
                if (val_len[31]) begin
                  nulls[1] = 1'b1;
                  phase    = PH_DONE;
                end else begin
                  phase = (val_len == 0) ? PH_DONE : PH_VALUE;
                end
              end
            end
            PH_VALUE: begin
              emit(KIND_VALUE, b, ST_GOOD);
              byte_cnt = byte_cnt + 1;
              if (byte_cnt >= val_len) begin
                byte_cnt = '0;
                phase    = PH_DONE;
              end
            end
            default: phase = PH_TRAIL;
          endcase
          if (body_left == 0) begin
            close_message();
            ended = 1'b1;
          end
        end
      endcase
      if (beat.set_end) begin
        if (!ended) emit(KIND_STATUS, 8'h00, ST_TRUNCATED);
        power_up();
      end else if (ended) begin
        clear_message();
      end
      if (fresh.size() != 0) fresh[fresh.size() - 1].last_of_run = 1'b1;
      awaited = {awaited, fresh};
    endfunction

    task report(string what);
      $display("ERROR @%0t: %s", $time, what);
      errors++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got %0h, want %0h", beats_checked, name, got, want));
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected beat %0h", got));
        return;
      end
      want = awaited.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("payload_byte", got.payload_byte, want.payload_byte);
      compare_field("message_offset", got.message_offset, want.message_offset);
      compare_field("status", got.status, want.status);
      compare_field("key_null", got.key_null, want.key_null);
      compare_field("value_null", got.value_null, want.value_null);
      compare_field("last_of_run", got.last_of_run, want.last_of_run);
      if (want.kind == KIND_STATUS) status_seen[want.status]++;
      beats_checked++;
    endtask
  endclass

endpackage

// ===== verif/tb_log_message_set_deframer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_log_message_set_deframer
// Self-checking bench for the message set deframer.
// ----------------------------------------------------------------------------
// Message sets are built byte by byte (well-formed messages with random
// content, plus truncated sets, bad CRCs, odd lengths, unframeable sizes and
// plain noise) and streamed in with random gaps. Every accepted byte goes
// through a byte-level parser model that queues the expected result beats;
// every accepted output beat is checked field by field against the oldest.
// ----------------------------------------------------------------------------
module tb_log_message_set_deframer;
  import msd_pkg::*;
  import msd_tb_pkg::*;

  localparam int unsigned ITEMS     = 1900;   // input bytes to aim for
  localparam int unsigned HOLD_LEN  = 200;    // long receiver hold-off
  localparam int unsigned DRAIN_MAX = 20000;  // cycles allowed to drain

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  deframe_scoreboard sb;

  // bytes of the set being built
  logic [7:0] set_q[$];
  int unsigned bytes_sent;

  log_message_set_deframer #(
    .LENGTH_BITS (LEN_BITS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("log_message_set_deframer regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------- builders

  // Append the low n bytes of v, most significant first
  task automatic push_word(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) set_q = {set_q, v[8*i +: 8]};
  endtask

  // One message. Declared key/value lengths are separate from the number of
  // bytes actually placed, so lengths that disagree with the size can be made.
  // 'cut' drops bytes from the end of the body (size and CRC follow the cut).
  task automatic add_message(input logic [63:0] off,
                             input logic [31:0] klen_f, input int kn,
                             input logic [31:0] vlen_f, input int vn,
                             input logic [7:0] attr, input int extra,
                             input int cut, input bit bad_crc);
    logic [7:0]  body[$];
    logic [31:0] crc;
    body = {};
    body = {body, 8'($urandom)};                        // magic
    body = {body, attr};
    for (int i = 3; i >= 0; i--) body = {body, klen_f[8*i +: 8]};
    repeat (kn) body = {body, 8'($urandom)};
    for (int i = 3; i >= 0; i--) body = {body, vlen_f[8*i +: 8]};
    repeat (vn) body = {body, 8'($urandom)};
    repeat (extra) body = {body, 8'($urandom)};
    repeat (cut) if (body.size() != 0) void'(body.pop_back());
    crc = CRC_INIT;
    foreach (body[i]) crc = crc_step(crc, body[i]);
    crc = ~crc;
    if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(31, 0));
    push_word(off, 8);
    push_word(64'(body.size() + 4), 4);
    push_word({32'd0, crc}, 4);
    set_q = {set_q, body};
  endtask

  // Random message, mostly well formed
  task automatic add_random_message();
    logic [31:0] klen_f, vlen_f;
    int          kn, vn, extra, cut;
    logic [7:0]  attr;
    kn = $urandom_range(6, 0);
    vn = $urandom_range(12, 0);
    klen_f = kn;
    vlen_f = vn;
    // null key or value: any negative length, no bytes
    if ($urandom_range(7, 0) == 0) begin
      klen_f = 32'h8000_0000 | $urandom;
      kn     = 0;
    end
    if ($urandom_range(7, 0) == 0) begin
      vlen_f = 32'h8000_0000 | $urandom;
      vn     = 0;
    end
    // declared length far beyond the body
    if ($urandom_range(19, 0) == 0) klen_f = $urandom & 32'h7FFF_FFFF;
    if ($urandom_range(19, 0) == 0) vlen_f = $urandom & 32'h7FFF_FFFF;
    attr  = ($urandom_range(6, 0) == 0) ? 8'($urandom) : {5'($urandom), 3'b000};
    extra = ($urandom_range(9, 0) == 0) ? $urandom_range(3, 1) : 0;
    cut   = ($urandom_range(9, 0) == 0) ? $urandom_range(4, 1) : 0;
    add_message({$urandom, $urandom}, klen_f, kn, vlen_f, vn, attr, extra, cut,
                $urandom_range(19, 0) == 0);
  endtask

  // ----------------------------------------------------------------- drivers

  // Entered and left just after a falling edge
  task automatic send_beat(input in_beat_t b, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_beat  = b;
    do @(posedge clk); while (in_stall);
    sb.parse_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_set();
    in_beat_t b;
    bit       calm;
    calm = ($urandom_range(3, 0) == 0);   // some sets go back to back
    foreach (set_q[i]) begin
      b.data_byte = set_q[i];
      b.set_end   = (i == set_q.size() - 1);
      send_beat(b, calm ? 0 : $urandom_range(3, 0));
    end
    set_q = {};
  endtask

  task automatic directed_sets();
    // lone byte with the end flag: truncation on a message's first byte
    set_q = {8'hFF};
    send_set();
    // set ends inside the offset field
    set_q = {8'h00, 8'h01, 8'h80, 8'h7F, 8'hAA};
    send_set();
    // offset extremes; null key and null value; set ends on a body end
    add_message(64'h8000_0000_0000_0000, 32'd3, 3, 32'd4, 4, 8'h00, 0, 0, 1'b0);
    add_message(64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0,
                8'h00, 0, 0, 1'b0);
    send_set();
    // empty body, zero lengths, compressed, trailing bytes, value cut short
    add_message(64'h0, 32'd0, 0, 32'd0, 0, 8'h00, 0, 99, 1'b0);
    add_message(64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 0, 32'd0, 0, 8'h00, 0, 0, 1'b0);
    add_message(64'h1, 32'd2, 2, 32'd2, 2, 8'h07, 0, 0, 1'b0);
    add_message(64'h2, 32'd1, 1, 32'd1, 1, 8'hF8, 3, 0, 1'b0);
    add_message(64'h3, 32'd2, 2, 32'd5, 5, 8'h00, 0, 3, 1'b0);
    send_set();
    // bad CRC: the message after it is dropped
    add_message(64'h55, 32'd1, 1, 32'd1, 1, 8'h00, 0, 0, 1'b1);
    add_message(64'h56, 32'd1, 1, 32'd1, 1, 8'h00, 0, 0, 1'b0);
    send_set();
    // unframeable sizes: below four, top bit set, and set ending on the size
    push_word(64'hA5A5_0000_0000_5A5A, 8);
    push_word(64'd3, 4);
    push_word(64'h0123_4567_89AB_CDEF, 8);
    send_set();
    push_word(64'h10, 8);
    push_word(64'h8000_0000, 4);
    push_word(64'h0, 3);
    send_set();
    push_word(64'h11, 8);
    push_word(64'hFFFF_FFFF, 4);
    send_set();
  endtask

  task automatic random_set();
    int pick, keep;
    pick = $urandom_range(99, 0);
    if (pick < 80) begin
      repeat ($urandom_range(4, 1)) add_random_message();
    end else if (pick < 90) begin
      // cut anywhere in the set
      repeat ($urandom_range(3, 1)) add_random_message();
      keep = $urandom_range(set_q.size() - 1, 1);
      while (set_q.size() > keep) void'(set_q.pop_back());
    end else if (pick < 95) begin
      repeat ($urandom_range(30, 1)) set_q = {set_q, 8'($urandom)};
    end else begin
      if ($urandom_range(1, 0)) add_random_message();
      push_word({$urandom, $urandom}, 8);
      push_word($urandom_range(1, 0) ? 64'($urandom_range(3, 0))
                                     : {32'd0, 32'h8000_0000 | $urandom}, 4);
      repeat ($urandom_range(10, 0)) set_q = {set_q, 8'($urandom)};
    end
    send_set();
  endtask

  // ----------------------------------------------------------------- receiver
  // Random stalls per beat, quiet stretches, and now and then a long hold-off
  // while the sender keeps going so the result queue fills and input stalls.
  initial begin
    int unsigned got;
    int unsigned hold;
    bit          calm;
    got  = 0;
    calm = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (got % 40 == 0) calm = ($urandom_range(2, 0) == 0);
      hold = (got % 600 == 100) ? HOLD_LEN : (calm ? 0 : $urandom_range(3, 0));
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_beat(out_beat);
      got++;
      @(negedge clk);
    end
  end

  // ------------------------------------------------------------------- main
  initial begin
    int unsigned waited;
    sb         = new();
    bytes_sent = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_beat    = '0;
    out_stall  = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_sets();
    while (bytes_sent < ITEMS) random_set();
    in_valid = 1'b0;

    // drain, then allow for the input register and queue before looking for strays
    waited = 0;
    while (sb.awaited.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d expected beats never arrived", sb.awaited.size()));

    $display("%0d bytes streamed (%0d parsed), %0d result beats checked",
             bytes_sent, sb.live_bytes, sb.beats_checked);
    $display("statuses: good %0d, crc %0d, compressed %0d, truncated %0d, length %0d",
             sb.status_seen[ST_GOOD], sb.status_seen[ST_CRC],
             sb.status_seen[ST_COMPRESSED], sb.status_seen[ST_TRUNCATED],
             sb.status_seen[ST_LENGTH]);
    if (sb.errors == 0) begin
      $display("log_message_set_deframer regression: pass");
    end else begin
      $display("log_message_set_deframer regression: fail");
    end
    $finish;
  end

endmodule
